FILE: src/lpfd_pkg.sv
`default_nettype none

package lpfd_pkg;

   // Frame geometry
   localparam int unsigned LEN_BYTES = 4;
   localparam int unsigned HDR_BYTES = 6;

   // Parser phase
   typedef enum logic [1:0] {
      PH_LENGTH  = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   // Result kind codes
   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_SHORT   = 2'd2
   } kind_type;

   // One result beat
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  msg_type;
      logic [31:0] sequence_res;
      logic [7:0]  status_code;
      logic [7:0]  payload_byte;
      logic        last;
   } result_type;

endpackage

`default_nettype wire

FILE: src/lpfd_chan_if.sv
`default_nettype none

// Byte input channel
interface lpfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

// Result channel
interface lpfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  msg_type;
   logic [31:0] sequence_res;
   logic [7:0]  status_code;
   logic [7:0]  payload_byte;
   logic        last;

   modport source (output valid, output kind, output msg_type, output sequence_res,
                   output status_code, output payload_byte, output last, input ready);
   modport sink (input valid, input kind, input msg_type, input sequence_res,
                 input status_code, input payload_byte, input last, output ready);
endinterface

`default_nettype wire

FILE: src/lpfd_parser.sv
`default_nettype none

module lpfd_parser (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic [7:0]          in_byte,
   output logic                     res_valid,
   output lpfd_pkg::result_type     res
);
   import lpfd_pkg::*;

   localparam logic [2:0] LenLastIdx = 3'(LEN_BYTES);
   localparam logic [2:0] SeqEndIdx  = 3'(HDR_BYTES - 1);
   localparam logic [31:0] HdrLen    = 32'(HDR_BYTES);

   phase_type   phase_ff, phase_in;
   logic [2:0]  field_index_ff, field_index_in;
   logic [31:0] length_shift_ff, length_shift_in;
   logic [31:0] remaining_ff, remaining_in;
   logic [7:0]  held_type_ff, held_type_in;
   logic [31:0] held_sequence_ff, held_sequence_in;
   logic        short_body_ff, short_body_in;

   logic [31:0] rem_dec;
   logic        rem_done;
   logic [31:0] len_next;
   logic [2:0]  idx_inc;
   logic        len_full;

   assign rem_dec  = remaining_ff - 32'd1;
   assign rem_done = (rem_dec == 32'd0);
   assign len_next = {length_shift_ff[23:0], in_byte};
   assign idx_inc  = field_index_ff + 3'd1;
   assign len_full = (idx_inc >= LenLastIdx);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         case (phase_ff)
            PH_HEADER: begin
               if (short_body_ff) begin
                  if (rem_done) phase_in = PH_LENGTH;
               end else if (field_index_ff >= SeqEndIdx) begin
                  phase_in = rem_done ? PH_LENGTH : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               if (rem_done) phase_in = PH_LENGTH;
            end
            default: begin
               phase_in = (len_full && len_next != 32'd0) ? PH_HEADER : PH_LENGTH;
            end
         endcase
      end
   end

   // Datapath update and result
   always_comb begin
      field_index_in   = field_index_ff;
      length_shift_in  = length_shift_ff;
      remaining_in     = remaining_ff;
      held_type_in     = held_type_ff;
      held_sequence_in = held_sequence_ff;
      short_body_in    = short_body_ff;
      res_valid        = 1'b0;
      res              = '0;
      if (step) begin
         case (phase_ff)
            PH_HEADER: begin
               remaining_in = rem_dec;
               if (short_body_ff) begin
                  if (rem_done) begin
                     res_valid      = 1'b1;
                     res.kind       = KIND_SHORT;
                     res.last       = 1'b1;
                     field_index_in = '0;
                  end
               end else if (field_index_ff == 3'd0) begin
                  held_type_in   = in_byte;
                  field_index_in = idx_inc;
               end else if (field_index_ff < SeqEndIdx) begin
                  held_sequence_in = {held_sequence_ff[23:0], in_byte};
                  field_index_in   = idx_inc;
               end else begin
                  res_valid        = 1'b1;
                  res.kind         = KIND_HEADER;
                  res.msg_type     = held_type_ff;
                  res.sequence_res = held_sequence_ff;
                  res.status_code  = in_byte;
                  res.last         = rem_done;
                  field_index_in   = '0;
               end
            end
            PH_PAYLOAD: begin
               remaining_in     = rem_dec;
               res_valid        = 1'b1;
               res.kind         = KIND_PAYLOAD;
               res.payload_byte = in_byte;
               res.last         = rem_done;
            end
            default: begin
               length_shift_in = len_next;
               field_index_in  = idx_inc;
               if (len_full) begin
                  remaining_in     = len_next;
                  length_shift_in  = '0;
                  field_index_in   = '0;
                  held_type_in     = '0;
                  held_sequence_in = '0;
                  short_body_in    = (len_next < HdrLen);
                  // empty body is reported right away
                  if (len_next == 32'd0) begin
                     res_valid = 1'b1;
                     res.kind  = KIND_SHORT;
                     res.last  = 1'b1;
                  end
               end
            end
         endcase
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_LENGTH;
         field_index_ff   <= '0;
         length_shift_ff  <= '0;
         remaining_ff     <= '0;
         held_type_ff     <= '0;
         held_sequence_ff <= '0;
         short_body_ff    <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         field_index_ff   <= field_index_in;
         length_shift_ff  <= length_shift_in;
         remaining_ff     <= remaining_in;
         held_type_ff     <= held_type_in;
         held_sequence_ff <= held_sequence_in;
         short_body_ff    <= short_body_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/length_prefix_frame_deframer_core.sv
// Length-prefixed frame deframer.
// req_chan takes the raw byte stream, one byte per beat. Each frame is a
// 4-byte big-endian body length followed by the body: type, 4-byte
// big-endian sequence, code, then payload bytes.
// rsp_chan gives one header beat after the sixth body byte, then one beat
// per payload byte; the final beat of a frame has last set. A body shorter
// than six bytes gives a single error beat (kind 2) when its last byte
// arrives, or on the fourth length byte if the length is zero.
// Latency: a result beat is valid the cycle after the byte that caused it.
// Throughput: one byte per clock; the parser next state is combinational
// and the output register is refilled in the cycle it is drained.
// When the receiver stalls, the pending result holds in the output
// register and req_chan.ready drops until it is taken; bytes that cause
// no result are still taken only while the output can accept.
// Reset (synchronous) returns the parser to the length field and empties
// the output register.
`default_nettype none

module length_prefix_frame_deframer_core (
   input  wire logic clock,
   input  wire logic reset,
   lpfd_req_if.sink   req_chan,
   lpfd_rsp_if.source rsp_chan
);
   import lpfd_pkg::*;

   logic       accept;
   logic       res_valid;
   result_type res;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   // Input side may advance whenever the output slot is free or draining
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   lpfd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .in_byte   (req_chan.data_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   // Output slot occupancy
   always_comb begin
      if (accept) rsp_valid_in = res_valid;
      else        rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload register
   always_ff @(posedge clock) begin
      if (accept && res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kind         = rsp_data_ff.kind;
   assign rsp_chan.msg_type     = rsp_data_ff.msg_type;
   assign rsp_chan.sequence_res = rsp_data_ff.sequence_res;
   assign rsp_chan.status_code  = rsp_data_ff.status_code;
   assign rsp_chan.payload_byte = rsp_data_ff.payload_byte;
   assign rsp_chan.last         = rsp_data_ff.last;

endmodule

`default_nettype wire
